[rtl/shrl_pkg.sv]
// ----------------------------------------------------------------------------
// shrl_pkg - shared types and constants of the send history rate limiter
// Field widths, header overhead and the history entry record.
// ----------------------------------------------------------------------------
package shrl_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int SIZE_W            = 17;   // stored packet size incl. header
    localparam int STAMP_W           = 32;   // time units
    localparam int BYTES_W           = 16;   // payload bytes of an item
    localparam int HEADER_BYTES      = 34;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

[rtl/shrl_cell.sv]
// ----------------------------------------------------------------------------
// shrl_cell - one history slot of the send record chain
// Holds one size/stamp record and passes it on to the next cell on shift.
// ----------------------------------------------------------------------------
module shrl_cell
    import shrl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t entry_in,
    output entry_t entry_out
);

    entry_t entry_reg, entry_next;

    always_comb begin
        entry_next = shift_en ? entry_in : entry_reg;
    end

    // empty slot reads as size 0, stamp 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;

endmodule

[rtl/shrl_divider.sv]
// ----------------------------------------------------------------------------
// shrl_divider - restoring serial divider
// One quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module shrl_divider
    import shrl_pkg::*;
#(
    parameter int DIVIDEND_W = SIZE_W + 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [STAMP_W-1:0]    divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [STAMP_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [STAMP_W-1:0]    divisor_reg, divisor_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STAMP_W:0]      shifted;
    logic                  fits;

    always_comb begin
        shifted      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits         = (shifted >= {1'b0, divisor_reg});
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start) begin
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
            cnt_next     = CNT_W'(DIVIDEND_W);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so 32 bits hold it
            if (fits) begin
                rem_next = STAMP_W'(shifted - {1'b0, divisor_reg});
            end else begin
                rem_next = shifted[STAMP_W-1:0];
            end
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/send_history_rate_limiter.sv]
// ----------------------------------------------------------------------------
// send_history_rate_limiter - sliding window send permission check
// Keeps the last HISTORY_DEPTH sent-packet records and answers, per item,
// whether a packet may be sent at the given time.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A record item (cmd = 1) pushes its
// packet size plus a 34-byte header and its time into the history chain,
// dropping the oldest record; query and record items then get one send_ok
// item. With min_interval and max_rate both zero the answer comes right
// away. Otherwise the chain is rotated once through its HISTORY_DEPTH
// cells to gather total bytes and the oldest and newest nonzero times,
// followed by a check state; if the rate check is needed, a serial
// divider works out one quotient bit per cycle over the byte total
// (17 + clog2(HISTORY_DEPTH + 1) bits). The next item is accepted only
// once the answer to the last one is loaded into the output register.
// A new item is taken while the previous answer still waits on m_tready.
// Registers: min_interval at 0x0, max_rate at 0x4, to be written only
// while idle; the user must ensure this, the block does not enforce it.
// ----------------------------------------------------------------------------
module send_history_rate_limiter
    import shrl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] now, [47:32] packet_bytes
    input  logic        s_tuser,   // [0] cmd
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] send_ok, [7:1] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TOTAL_W = SIZE_W + $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_MAX_RATE     = 1'b1;

    // ---------------- configuration ----------------
    logic [STAMP_W-1:0] min_interval_reg, max_rate_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg <= '0;
            max_rate_reg     <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MIN_INTERVAL) begin
                min_interval_reg <= pwdata;
            end else begin
                max_rate_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_MAX_RATE) ? max_rate_reg : min_interval_reg;

    // ---------------- sequencer registers ----------------
    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [STAMP_W-1:0] oldest_reg, oldest_next;
    logic [STAMP_W-1:0] newest_reg, newest_next;
    logic               result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg, m_ok_next;

    logic               s_accept;
    logic               in_cmd;
    logic [STAMP_W-1:0] in_now;
    logic [BYTES_W-1:0] in_bytes;

    assign in_cmd   = s_tuser;
    assign in_now   = s_tdata[STAMP_W-1:0];
    assign in_bytes = s_tdata[STAMP_W +: BYTES_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    // ---------------- history chain ----------------
    // Record order does not matter to the answer, so the ring is a shift
    // chain: a record enters cell 0 and the oldest falls off the end.
    // A scan rotates the chain once, tail feeding back into cell 0.
    entry_t chain_out [HISTORY_DEPTH];
    entry_t chain_in  [HISTORY_DEPTH];
    entry_t new_entry;
    entry_t tail;
    logic   shift_en;
    logic   push;

    assign push     = s_accept & in_cmd;
    assign shift_en = push | (state_reg == ST_SCAN);
    assign tail     = chain_out[HISTORY_DEPTH-1];

    always_comb begin
        new_entry.size  = SIZE_W'({1'b0, in_bytes} + SIZE_W'(HEADER_BYTES));
        new_entry.stamp = in_now;
    end

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign chain_in[gi] = push ? new_entry : tail;
            end else begin : g_body
                assign chain_in[gi] = chain_out[gi-1];
            end
            shrl_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .entry_in  (chain_in[gi]),
                .entry_out (chain_out[gi])
            );
        end
    endgenerate

    // ---------------- rate divider ----------------
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_quotient;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] divisor;
    logic [STAMP_W-1:0] since_newest;

    // oldest never exceeds now, so the difference does not wrap
    assign elapsed      = now_reg - oldest_reg;
    assign divisor      = (elapsed == '0) ? STAMP_W'(1) : elapsed;
    assign since_newest = now_reg - newest_reg;

    shrl_divider #(
        .DIVIDEND_W (TOTAL_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ---------------- control ----------------
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        now_next     = now_reg;
        total_next   = total_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_ok_next    = m_ok_reg;
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    now_next    = in_now;
                    total_next  = '0;
                    oldest_next = in_now;
                    newest_next = '0;
                    cnt_next    = '0;
                    if (min_interval_reg == '0 && max_rate_reg == '0) begin
                        result_next = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // zero sizes add nothing; zero stamps mark empty slots
                total_next = total_reg + TOTAL_W'(tail.size);
                if (tail.stamp != '0) begin
                    if (tail.stamp < oldest_reg) begin
                        oldest_next = tail.stamp;
                    end
                    if (tail.stamp > newest_reg) begin
                        newest_next = tail.stamp;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HISTORY_DEPTH - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (since_newest < min_interval_reg) begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end else if (max_rate_reg == '0) begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    result_next = (STAMP_W'(div_quotient) <= max_rate_reg);
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        total_reg  <= total_next;
        oldest_reg <= oldest_next;
        newest_reg <= newest_next;
        result_reg <= result_next;
        m_ok_reg   <= m_ok_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_ok_reg};

endmodule
